// File: rtl/cbc_pkg.sv
package cbc_pkg;

   localparam int RAM_BANKS     = 4;
   localparam int ROM_BANK_BITS = 7;

   localparam int RAM_BANK_SIZE = 8192;
   localparam int RAM_DEPTH     = RAM_BANKS * RAM_BANK_SIZE;
   localparam int RAM_ADDR_W    = $clog2(RAM_DEPTH);
   localparam int OFFSET_W      = $clog2(RAM_BANK_SIZE);
   localparam int ROM_OFFSET_W  = 14;
   localparam int ROM_ADDR_W    = 21;
   localparam int BUS_ADDR_W    = 16;
   localparam int BANK_SEL_W    = 4;
   localparam int RTC_REGS      = 5;
   localparam int RTC_IDX_W     = $clog2(RTC_REGS);

   localparam logic [BANK_SEL_W-1:0] RAM_BANKS_SEL = BANK_SEL_W'(RAM_BANKS);
   localparam logic [BANK_SEL_W-1:0] RAM_SEL_LAST  = 4'h3;
   localparam logic [BANK_SEL_W-1:0] RTC_SEL_FIRST = 4'h8;
   localparam logic [BANK_SEL_W-1:0] RTC_SEL_LAST  = 4'hC;
   localparam logic [3:0]            ENABLE_KEY    = 4'hA;
   localparam logic [7:0]            BYTE_ONES     = 8'hFF;

   // top three address bits of the cartridge RAM window
   localparam logic [2:0] REGION_RAM = 3'b101;

   typedef enum logic [1:0] {
      REG_ENABLE   = 2'd0,
      REG_ROM_BANK = 2'd1,
      REG_RAM_BANK = 2'd2,
      REG_LATCH    = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_ONES,
      SRC_RTC,
      SRC_RAM
   } src_type;

   typedef struct packed {
      logic                     ram_enabled;
      logic [BANK_SEL_W-1:0]    ram_sel;
      logic [ROM_BANK_BITS-1:0] rom_page;
   } state_type;

   typedef struct packed {
      logic                  enable_we;
      logic                  rom_page_we;
      logic                  ram_sel_we;
      logic                  rtc_we;
      logic                  ram_we;
      logic                  ram_re;
      logic [RTC_IDX_W-1:0]  rtc_idx;
      logic [RAM_ADDR_W-1:0] ram_addr;
      src_type               src;
      logic                  rom_select;
      logic [ROM_ADDR_W-1:0] rom_address;
   } ctrl_type;

endpackage

// File: rtl/cartridge_bank_controller_unit.sv
// Bank controller for a game cartridge: each request word is one CPU bus access
// (read/write, 16-bit address, byte). Reads below 0x8000 return rsp_rom_select and
// a 21-bit mapped address for the external ROM; 0xA000-0xBFFF reaches banked RAM
// or the RTC bytes while RAM is enabled; writes below 0x8000 set enable, ROM bank
// and RAM bank (latch writes are ignored). Every access gives one response word.
// Throughput is one word per cycle while rsp_stall is low. A request passes the input
// register, then decode and a single-port RAM access into the response register,
// and rsp_valid rises once the response register is loaded. A stalled response
// holds the pipe.
module cartridge_bank_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [cbc_pkg::BUS_ADDR_W-1:0]      req_address,
   input  logic [7:0]                          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_read_data,
   output logic                                rsp_rom_select,
   output logic [cbc_pkg::ROM_ADDR_W-1:0]      rsp_rom_address
);

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic                              in_action_ff;
   logic [cbc_pkg::BUS_ADDR_W-1:0]    in_address_ff;
   logic [7:0]                        in_data_ff;

   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic                              out_ram_ff;
   logic [7:0]                        out_data_ff;
   logic [7:0]                        out_data_in;
   logic                              out_rom_select_ff;
   logic [cbc_pkg::ROM_ADDR_W-1:0]    out_rom_address_ff;

   logic                              advance;
   logic                              fire;
   cbc_pkg::state_type                state;
   cbc_pkg::ctrl_type                 ctrl;
   logic [7:0]                        rtc_rdata;
   logic [7:0]                        ram_rdata;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      case (ctrl.src)
         cbc_pkg::SRC_ONES: out_data_in = cbc_pkg::BYTE_ONES;
         cbc_pkg::SRC_RTC:  out_data_in = rtc_rdata;
         default:           out_data_in = '0;
      endcase
   end

   cbc_decode u_decode (
      .action  (in_action_ff),
      .address (in_address_ff),
      .state   (state),
      .ctrl    (ctrl)
   );

   cbc_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .ctrl       (ctrl),
      .write_data (in_data_ff),
      .state      (state),
      .rtc_rdata  (rtc_rdata)
   );

   cbc_ram u_ram (
      .clock (clock),
      .we    (fire && ctrl.ram_we),
      .re    (fire && ctrl.ram_re),
      .addr  (ctrl.ram_addr),
      .wdata (in_data_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_action_ff  <= req_action;
         in_address_ff <= req_address;
         in_data_ff    <= req_write_data;
      end
      if (fire) begin
         out_ram_ff         <= (ctrl.src == cbc_pkg::SRC_RAM);
         out_data_ff        <= out_data_in;
         out_rom_select_ff  <= ctrl.rom_select;
         out_rom_address_ff <= ctrl.rom_address;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = out_ram_ff ? ram_rdata : out_data_ff;
   assign rsp_rom_select  = out_rom_select_ff;
   assign rsp_rom_address = out_rom_address_ff;

endmodule

// File: rtl/cbc_decode.sv
module cbc_decode (
   input  logic                                 action,
   input  logic [cbc_pkg::BUS_ADDR_W-1:0]       address,
   input  cbc_pkg::state_type                   state,
   output cbc_pkg::ctrl_type                    ctrl
);

   logic        is_write;
   logic [3:0]  bank;
   cbc_pkg::reg_sel_type reg_sel;

   always_comb begin
      is_write = action;
      bank     = state.ram_sel;
      reg_sel  = cbc_pkg::reg_sel_type'(address[14:13]);

      ctrl             = '0;
      ctrl.src         = cbc_pkg::SRC_ZERO;
      ctrl.rtc_idx     = cbc_pkg::RTC_IDX_W'(bank - cbc_pkg::RTC_SEL_FIRST);
      ctrl.ram_addr    = cbc_pkg::RAM_ADDR_W'({bank[1:0],
                                               address[cbc_pkg::OFFSET_W-1:0]});

      if (address[15:13] == cbc_pkg::REGION_RAM) begin
         if (state.ram_enabled) begin
            if (bank <= cbc_pkg::RAM_SEL_LAST) begin
               if (bank < cbc_pkg::RAM_BANKS_SEL) begin
                  ctrl.ram_we = is_write;
                  ctrl.ram_re = !is_write;
                  if (!is_write) begin
                     ctrl.src = cbc_pkg::SRC_RAM;
                  end
               end else if (!is_write) begin
                  ctrl.src = cbc_pkg::SRC_ONES;
               end
            end else if (bank inside {[cbc_pkg::RTC_SEL_FIRST:cbc_pkg::RTC_SEL_LAST]}) begin
               ctrl.rtc_we = is_write;
               if (!is_write) begin
                  ctrl.src = cbc_pkg::SRC_RTC;
               end
            end else if (!is_write) begin
               ctrl.src = cbc_pkg::SRC_ONES;
            end
         end
      end else if (is_write) begin
         if (!address[15]) begin
            case (reg_sel)
               cbc_pkg::REG_ENABLE:   ctrl.enable_we   = 1'b1;
               cbc_pkg::REG_ROM_BANK: ctrl.rom_page_we = 1'b1;
               cbc_pkg::REG_RAM_BANK: ctrl.ram_sel_we  = 1'b1;
               cbc_pkg::REG_LATCH:    ;
               default:               ;
            endcase
         end
      end else if (!address[15]) begin
         ctrl.rom_select = 1'b1;
         if (!address[14]) begin
            ctrl.rom_address = cbc_pkg::ROM_ADDR_W'(address);
         end else begin
            ctrl.rom_address = cbc_pkg::ROM_ADDR_W'({state.rom_page,
                                                     address[cbc_pkg::ROM_OFFSET_W-1:0]});
         end
      end
   end

endmodule

// File: rtl/cbc_regs.sv
module cbc_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  cbc_pkg::ctrl_type                ctrl,
   input  logic [7:0]                       write_data,
   output cbc_pkg::state_type               state,
   output logic [7:0]                       rtc_rdata
);

   logic                              ram_enabled_ff;
   logic [cbc_pkg::BANK_SEL_W-1:0]    ram_sel_ff;
   logic [cbc_pkg::ROM_BANK_BITS-1:0] rom_page_ff;
   logic [7:0]                        rtc_ff [cbc_pkg::RTC_REGS];
   logic [cbc_pkg::ROM_BANK_BITS-1:0] rom_page_in;

   always_comb begin
      rom_page_in = write_data[cbc_pkg::ROM_BANK_BITS-1:0];
      if (rom_page_in == '0) begin
         rom_page_in = cbc_pkg::ROM_BANK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_enabled_ff <= 1'b0;
         ram_sel_ff     <= '0;
         rom_page_ff    <= cbc_pkg::ROM_BANK_BITS'(1);
         for (int i = 0; i < cbc_pkg::RTC_REGS; i++) begin
            rtc_ff[i] <= '0;
         end
      end else if (fire) begin
         if (ctrl.enable_we) begin
            ram_enabled_ff <= (write_data[3:0] == cbc_pkg::ENABLE_KEY);
         end
         if (ctrl.rom_page_we) begin
            rom_page_ff <= rom_page_in;
         end
         if (ctrl.ram_sel_we) begin
            ram_sel_ff <= write_data[cbc_pkg::BANK_SEL_W-1:0];
         end
         if (ctrl.rtc_we) begin
            rtc_ff[ctrl.rtc_idx] <= write_data;
         end
      end
   end

   assign state.ram_enabled = ram_enabled_ff;
   assign state.ram_sel     = ram_sel_ff;
   assign state.rom_page    = rom_page_ff;
   assign rtc_rdata         = rtc_ff[ctrl.rtc_idx];

endmodule

// File: rtl/cbc_ram.sv
module cbc_ram (
   input  logic                            clock,
   input  logic                            we,
   input  logic                            re,
   input  logic [cbc_pkg::RAM_ADDR_W-1:0]  addr,
   input  logic [7:0]                      wdata,
   output logic [7:0]                      rdata
);

   logic [7:0] mem [cbc_pkg::RAM_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sim/cartridge_bank_controller_unit_test.sv
`timescale 1ns / 1ps

module cartridge_bank_controller_unit_test;

   localparam logic BUS_READ     = 1'b0;
   localparam logic BUS_WRITE    = 1'b1;
   localparam int   RANDOM_ITEMS = 1700;
   localparam int   CALM_TAIL    = 250;
   localparam int   QUIET_LIMIT  = 1000;
   localparam int   DRAIN_CYCLES = 8;

   typedef struct packed {
      logic                           action;
      logic [cbc_pkg::BUS_ADDR_W-1:0] address;
      logic [7:0]                     write_data;
   } bus_access_type;

   typedef struct packed {
      logic [7:0]                     read_data;
      logic                           rom_select;
      logic [cbc_pkg::ROM_ADDR_W-1:0] rom_address;
   } bus_result_type;

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_stall;
   logic                           req_action     = BUS_READ;
   logic [cbc_pkg::BUS_ADDR_W-1:0] req_address    = '0;
   logic [7:0]                     req_write_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall      = 1'b0;
   logic [7:0]                     rsp_read_data;
   logic                           rsp_rom_select;
   logic [cbc_pkg::ROM_ADDR_W-1:0] rsp_rom_address;

   cartridge_bank_controller_unit u_top (.*);

   // expected controller state
   logic [7:0]                        cart_ram [cbc_pkg::RAM_DEPTH];
   logic [cbc_pkg::ROM_BANK_BITS-1:0] rom_page  = cbc_pkg::ROM_BANK_BITS'(1);
   logic [cbc_pkg::BANK_SEL_W-1:0]    ram_sel   = '0;
   logic                              ram_on    = 1'b0;
   logic [7:0]                        rtc_bytes [cbc_pkg::RTC_REGS] = '{default: '0};

   // stimulus-side view, used to keep reads on written RAM and to sort accesses for the counts
   logic                           gen_ram_on = 1'b0;
   logic [cbc_pkg::BANK_SEL_W-1:0] gen_bank   = '0;
   bit                             ram_written [cbc_pkg::RAM_DEPTH];
   int                             written_ofs [cbc_pkg::RAM_BANKS][$];

   bus_access_type pending_accesses [$];
   bus_result_type expected_responses [$];
   bus_access_type next_access;
   bus_access_type taken_access;
   bus_result_type got;
   bus_result_type want;

   logic req_taken    = 1'b0;
   int   req_gap      = 0;
   int   stall_left   = 0;
   int   words_sent   = 0;
   int   quiet_cycles = 0;
   int   mismatch_count = 0;
   int   responses_seen = 0;
   int   counted_items  = 0;
   int   rom_reads      = 0;
   int   window_hits    = 0;
   int   reg_writes     = 0;
   int   other_accesses = 0;

   initial forever #5 clock = ~clock;

   function automatic bus_result_type bus_response_for(bus_access_type a);
      bus_result_type r;
      int idx;
      r = '0;
      if (a.address[15:13] == cbc_pkg::REGION_RAM) begin
         if (ram_on) begin
            if (ram_sel <= cbc_pkg::RAM_SEL_LAST) begin
               if (ram_sel < cbc_pkg::RAM_BANKS_SEL) begin
                  idx = (int'(ram_sel) * cbc_pkg::RAM_BANK_SIZE
                         + int'(a.address[cbc_pkg::OFFSET_W-1:0])) % cbc_pkg::RAM_DEPTH;
                  if (a.action == BUS_WRITE) cart_ram[idx] = a.write_data;
                  else r.read_data = cart_ram[idx];
               end else if (a.action == BUS_READ) begin
                  r.read_data = cbc_pkg::BYTE_ONES;
               end
            end else if (ram_sel >= cbc_pkg::RTC_SEL_FIRST
                         && ram_sel <= cbc_pkg::RTC_SEL_LAST) begin
               idx = int'(ram_sel) - int'(cbc_pkg::RTC_SEL_FIRST);
               if (a.action == BUS_WRITE) rtc_bytes[idx] = a.write_data;
               else r.read_data = rtc_bytes[idx];
            end else if (a.action == BUS_READ) begin
               r.read_data = cbc_pkg::BYTE_ONES;
            end
         end
      end else if (a.action == BUS_WRITE) begin
         if (!a.address[15]) begin
            case (cbc_pkg::reg_sel_type'(a.address[14:13]))
               cbc_pkg::REG_ENABLE: ram_on = a.write_data[3:0] == cbc_pkg::ENABLE_KEY;
               cbc_pkg::REG_ROM_BANK: begin
                  rom_page = a.write_data[cbc_pkg::ROM_BANK_BITS-1:0];
                  if (rom_page == '0) rom_page = cbc_pkg::ROM_BANK_BITS'(1);
               end
               cbc_pkg::REG_RAM_BANK: ram_sel = a.write_data[cbc_pkg::BANK_SEL_W-1:0];
               cbc_pkg::REG_LATCH: ;
               default: ;
            endcase
         end
      end else if (!a.address[15]) begin
         r.rom_select = 1'b1;
         if (!a.address[14]) r.rom_address = cbc_pkg::ROM_ADDR_W'(a.address);
         else r.rom_address = cbc_pkg::ROM_ADDR_W'(
                 int'(rom_page) * (1 << cbc_pkg::ROM_OFFSET_W)
                 + int'(a.address[cbc_pkg::ROM_OFFSET_W-1:0]));
      end
      return r;
   endfunction

   task automatic queue_access(logic action, logic [cbc_pkg::BUS_ADDR_W-1:0] address,
                               logic [7:0] data);
      bus_access_type a;
      int idx;
      bit window;
      bit ram_hit;
      window  = address[15:13] == cbc_pkg::REGION_RAM;
      ram_hit = window && gen_ram_on && gen_bank < cbc_pkg::RAM_BANKS_SEL;
      idx     = 0;
      if (ram_hit) begin
         idx = int'(gen_bank) * cbc_pkg::RAM_BANK_SIZE
               + int'(address[cbc_pkg::OFFSET_W-1:0]);
         if (action == BUS_READ && !ram_written[idx]) action = BUS_WRITE;
      end
      if (action == BUS_READ && !address[15]) rom_reads++;
      else if (window && gen_ram_on) window_hits++;
      else if (action == BUS_WRITE && !address[15] && address[14:13] != cbc_pkg::REG_LATCH)
         reg_writes++;
      else other_accesses++;
      if (!(action == BUS_WRITE && (address[15] || address[14:13] == cbc_pkg::REG_LATCH)
            && !(window && gen_ram_on)))
         counted_items++;
      if (action == BUS_WRITE) begin
         if (ram_hit && !ram_written[idx]) begin
            ram_written[idx] = 1'b1;
            written_ofs[gen_bank].push_back(int'(address[cbc_pkg::OFFSET_W-1:0]));
         end else if (!address[15]) begin
            case (cbc_pkg::reg_sel_type'(address[14:13]))
               cbc_pkg::REG_ENABLE:   gen_ram_on = data[3:0] == cbc_pkg::ENABLE_KEY;
               cbc_pkg::REG_RAM_BANK: gen_bank = data[cbc_pkg::BANK_SEL_W-1:0];
               default: ;
            endcase
         end
      end
      a = '{action, address, data};
      pending_accesses.push_back(a);
   endtask

   function automatic logic [cbc_pkg::BUS_ADDR_W-1:0] reg_addr(cbc_pkg::reg_sel_type sel);
      return {1'b0, sel, 13'($urandom)};
   endfunction

   function automatic logic [cbc_pkg::BANK_SEL_W-1:0] pick_selector();
      int r;
      r = $urandom_range(0, 19);
      if (r < 11)
         return cbc_pkg::BANK_SEL_W'($urandom_range(0, int'(cbc_pkg::RAM_SEL_LAST)));
      if (r < 18)
         return cbc_pkg::BANK_SEL_W'($urandom_range(int'(cbc_pkg::RTC_SEL_FIRST),
                                                    int'(cbc_pkg::RTC_SEL_LAST)));
      return cbc_pkg::BANK_SEL_W'($urandom);
   endfunction

   task automatic rom_session();
      logic [7:0] bank_byte;
      bank_byte = ($urandom_range(0, 7) == 0) ? {1'($urandom), 7'h00} : 8'($urandom);
      queue_access(BUS_WRITE, reg_addr(cbc_pkg::REG_ROM_BANK), bank_byte);
      repeat ($urandom_range(1, 6))
         queue_access(BUS_READ, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
   endtask

   task automatic ram_session();
      int r;
      int ofs;
      logic [7:0] off_byte;
      queue_access(BUS_WRITE, reg_addr(cbc_pkg::REG_ENABLE),
                   {4'($urandom), cbc_pkg::ENABLE_KEY});
      queue_access(BUS_WRITE, reg_addr(cbc_pkg::REG_RAM_BANK),
                   {4'($urandom), pick_selector()});
      repeat ($urandom_range(2, 14)) begin
         r = $urandom_range(0, 9);
         if (r < 4) begin
            ofs = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(0, cbc_pkg::RAM_BANK_SIZE - 1);
            queue_access(BUS_WRITE, {cbc_pkg::REGION_RAM, 13'(ofs)}, 8'($urandom));
         end else if (r < 8) begin
            ofs = $urandom_range(0, cbc_pkg::RAM_BANK_SIZE - 1);
            if (gen_bank < cbc_pkg::RAM_BANKS_SEL && written_ofs[gen_bank].size() != 0)
               ofs = written_ofs[gen_bank][$urandom_range(0, written_ofs[gen_bank].size() - 1)];
            queue_access(BUS_READ, {cbc_pkg::REGION_RAM, 13'(ofs)}, 8'($urandom));
         end else if (r == 8) begin
            rom_session();
         end else begin
            queue_access(BUS_READ, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
         end
      end
      if ($urandom_range(0, 1) == 0) begin
         off_byte = 8'($urandom);
         if (off_byte[3:0] == cbc_pkg::ENABLE_KEY) off_byte[3:0] = 4'h0;
         queue_access(BUS_WRITE, reg_addr(cbc_pkg::REG_ENABLE), off_byte);
      end
   endtask

   function automatic bit idling_on();
      return pending_accesses.size() > CALM_TAIL && ((words_sent / 160) % 4) != 3;
   endfunction

   task automatic note_mismatch(string field, logic [31:0] exp_val, logic [31:0] got_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("response %0d: %s expected 0x%0h, got 0x%0h",
                  responses_seen, field, exp_val, got_val);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (pending_accesses.size() != 0) begin
               next_access    = pending_accesses.pop_front();
               req_action     <= next_access.action;
               req_address    <= next_access.address;
               req_write_data <= next_access.write_data;
               req_valid      <= 1'b1;
               words_sent     <= words_sent + 1;
               if (idling_on() && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 3);
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (idling_on() && $urandom_range(0, 6) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            got = '{rsp_read_data, rsp_rom_select, rsp_rom_address};
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response %0d: word with nothing pending (data 0x%0h, addr 0x%0h)",
                           responses_seen, got.read_data, got.rom_address);
            end else begin
               want = expected_responses.pop_front();
               if (got.read_data !== want.read_data)
                  note_mismatch("read_data", 32'(want.read_data), 32'(got.read_data));
               if (got.rom_select !== want.rom_select)
                  note_mismatch("rom_select", 32'(want.rom_select), 32'(got.rom_select));
               if (got.rom_address !== want.rom_address)
                  note_mismatch("rom_address", 32'(want.rom_address), 32'(got.rom_address));
            end
         end
         if (req_valid && !req_stall) begin
            taken_access = '{req_action, req_address, req_write_data};
            expected_responses.push_back(bus_response_for(taken_access));
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int r;
      // ROM windows at reset, RAM off
      queue_access(BUS_READ,  16'h0000, 8'h00);
      queue_access(BUS_READ,  16'h3FFF, 8'hFF);
      queue_access(BUS_READ,  16'h4000, 8'h00);
      queue_access(BUS_READ,  16'h7FFF, 8'h00);
      queue_access(BUS_READ,  16'hA000, 8'h00);
      queue_access(BUS_WRITE, 16'hBFFF, 8'hFF);
      // ROM bank of zero maps to one
      queue_access(BUS_WRITE, 16'h2000, 8'h00);
      queue_access(BUS_READ,  16'h5ABC, 8'h00);
      queue_access(BUS_WRITE, 16'h3FFF, 8'hFF);
      queue_access(BUS_READ,  16'h7FFF, 8'h00);
      queue_access(BUS_WRITE, 16'h2000, 8'h80);
      queue_access(BUS_READ,  16'h4001, 8'h00);
      // RAM on, top bank, then RTC, unmapped selector, latch and other space
      queue_access(BUS_WRITE, 16'h0000, 8'hFA);
      queue_access(BUS_WRITE, 16'h4000, 8'h03);
      queue_access(BUS_WRITE, 16'hBFFF, 8'hA5);
      queue_access(BUS_READ,  16'hBFFF, 8'h00);
      queue_access(BUS_WRITE, 16'h5FFF, 8'h08);
      queue_access(BUS_WRITE, 16'hA000, 8'h3C);
      queue_access(BUS_READ,  16'hB123, 8'h00);
      queue_access(BUS_WRITE, 16'h4000, 8'h05);
      queue_access(BUS_WRITE, 16'hA000, 8'h77);
      queue_access(BUS_READ,  16'hA000, 8'h00);
      queue_access(BUS_WRITE, 16'h6000, 8'h01);
      queue_access(BUS_READ,  16'h9FFF, 8'h00);
      queue_access(BUS_WRITE, 16'hFFFF, 8'hFF);
      queue_access(BUS_READ,  16'hC000, 8'h00);
      queue_access(BUS_WRITE, 16'h1FFF, 8'hFB);

      counted_items = 0;
      while (counted_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 19);
         if (r < 11) begin
            ram_session();
         end else if (r < 16) begin
            rom_session();
         end else begin
            repeat ($urandom_range(1, 4))
               queue_access(1'($urandom), 16'($urandom), 8'($urandom));
         end
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_accesses.size() != 0 || req_valid) @(posedge clock);
      @(negedge clock);
      while (expected_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d bus words: %0d ROM reads, %0d RAM/RTC accesses with RAM on,",
               words_sent, rom_reads, window_hits);
      $display("%0d register writes, %0d ignored or unmapped; %0d response words checked",
               reg_writes, other_accesses, responses_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cbc_pkg.sv
rtl/cbc_decode.sv
rtl/cbc_regs.sv
rtl/cbc_ram.sv
rtl/cartridge_bank_controller_unit.sv
sim/cartridge_bank_controller_unit_test.sv
